// File: sv/ubx_frame_parser_fletcher_top_assert.svh
// Assertion macros used by the checker of the frame parser.
// Each macro samples on the rising edge of aclk.
`ifndef UBX_FRAME_PARSER_FLETCHER_TOP_ASSERT_SVH
`define UBX_FRAME_PARSER_FLETCHER_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define UBXFP_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define UBXFP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define UBXFP_ASSERT_NEXT_ALWAYS(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ubxfp_pkg.sv
package ubxfp_pkg;

    // Width of the frame position counter: sync, header, payload and checksum.
    localparam int POS_W = 17;

    typedef logic [POS_W-1:0] pos_t;

    // Fixed positions within a frame.
    localparam pos_t POS_SYNC_FIRST  = pos_t'(0);
    localparam pos_t POS_SYNC_SECOND = pos_t'(1);
    localparam pos_t POS_CLASS       = pos_t'(2);
    localparam pos_t POS_ID          = pos_t'(3);
    localparam pos_t POS_LEN_LOW     = pos_t'(4);
    localparam pos_t POS_LEN_HIGH    = pos_t'(5);
    localparam pos_t POS_PAYLOAD     = pos_t'(6);

    // Reset values of the sync bytes.
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'd181;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'd98;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 1'b0,
        CFG_SYNC_SECOND = 1'b1
    } cfg_index_t;

    // Result status codes, carried on tuser.
    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_HDR  = 3'd1,
        ST_PAY  = 3'd2,
        ST_CKA  = 3'd3,
        ST_GOOD = 3'd4,
        ST_BAD  = 3'd5
    } status_t;

    // One result item; the packed layout matches m_tdata from the top bit down.
    typedef struct packed {
        logic [15:0] frame_length;
        logic [7:0]  frame_id;
        logic [7:0]  frame_class;
        logic [15:0] payload_offset;
        logic [7:0]  data_out;
    } result_data_t;

endpackage

// File: sv/ubx_frame_parser_fletcher_top.sv
// Streaming parser for a two-sync-byte binary frame with an 8-bit Fletcher checksum.
// Every byte accepted on the s_ channel yields exactly one result on the m_ channel in the
// cycle after, and a new byte is accepted every cycle while the result is taken
// (tready stays high while the output register is empty or is being emptied), so the
// sustained rate is one byte per clock; the loops are the frame position counter with the
// captured length, and the Fletcher sum pair. The result carries the status
// code on m_tuser, the echoed byte, the payload offset and the captured header on
// m_tdata, and m_tlast marks the byte that ends a frame, good or bad. The sync bytes
// are set through the configuration channel, which always accepts, and should only be
// written while no result is pending.
module ubx_frame_parser_fletcher_top
    import ubxfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,

    // Received byte stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte

    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] data_out, [23:8] payload_offset, [31:24] frame_class,
    // [39:32] frame_id, [55:40] frame_length
    output logic [55:0]          m_tdata,
    output logic [2:0]           m_tuser,   // [2:0] status
    output logic                 m_tlast    // frame_end
);

    logic [7:0]   sync_first_reg;
    logic [7:0]   sync_second_reg;

    pos_t         pos_reg, pos_next;
    logic [7:0]   class_reg, class_next;
    logic [7:0]   id_reg, id_next;
    logic [15:0]  len_reg, len_next;
    logic [7:0]   sum_a_reg, sum_a_next;
    logic [7:0]   sum_b_reg, sum_b_next;

    logic         m_valid_reg, m_valid_next;
    result_data_t data_reg, data_next;
    status_t      status_reg, status_next;
    logic         last_reg, last_next;

    logic         accept;
    pos_t         cka_pos;
    logic [7:0]   sum_a_add;
    logic [7:0]   sum_b_add;
    pos_t         pay_index;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A new byte is taken whenever the output register is free or is being emptied.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cka_pos   = pos_t'({1'b0, len_reg}) + POS_PAYLOAD;
    assign sum_a_add = sum_a_reg + s_tdata;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign pay_index = pos_reg - POS_PAYLOAD;

    // Frame tracking and the result for the byte on s_tdata.
    always_comb begin
        pos_next    = pos_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        status_next = ST_HUNT;
        last_next   = 1'b0;
        data_next.payload_offset = '0;

        if (pos_reg == POS_SYNC_FIRST) begin
            pos_next = (s_tdata == sync_first_reg) ? POS_SYNC_SECOND : POS_SYNC_FIRST;
        end else if (pos_reg == POS_SYNC_SECOND) begin
            pos_next = (s_tdata == sync_second_reg) ? POS_CLASS : POS_SYNC_FIRST;
        end else if (pos_reg < POS_PAYLOAD) begin
            if (pos_reg == POS_CLASS) begin
                class_next = s_tdata;
            end else if (pos_reg == POS_ID) begin
                id_next = s_tdata;
            end else if (pos_reg == POS_LEN_LOW) begin
                len_next = {len_reg[15:8], s_tdata};
            end else begin
                len_next = {s_tdata, len_reg[7:0]};
            end
            sum_a_next  = sum_a_add;
            sum_b_next  = sum_b_add;
            status_next = ST_HDR;
            pos_next    = pos_reg + pos_t'(1);
        end else if (pos_reg < cka_pos) begin
            data_next.payload_offset = pay_index[15:0];
            sum_a_next  = sum_a_add;
            sum_b_next  = sum_b_add;
            status_next = ST_PAY;
            pos_next    = pos_reg + pos_t'(1);
        end else if (pos_reg == cka_pos) begin
            if (s_tdata == sum_a_reg) begin
                status_next = ST_CKA;
                pos_next    = pos_reg + pos_t'(1);
            end else begin
                // First checksum byte wrong: the frame is dropped here.
                status_next = ST_BAD;
                last_next   = 1'b1;
                pos_next    = POS_SYNC_FIRST;
                sum_a_next  = '0;
                sum_b_next  = '0;
            end
        end else if (pos_reg == cka_pos + pos_t'(1)) begin
            status_next = (s_tdata == sum_b_reg) ? ST_GOOD : ST_BAD;
            last_next   = 1'b1;
            pos_next    = POS_SYNC_FIRST;
            sum_a_next  = '0;
            sum_b_next  = '0;
        end else begin
            // A position past the checksum cannot occur; fall back to hunting.
            pos_next   = POS_SYNC_FIRST;
            sum_a_next = '0;
            sum_b_next = '0;
        end

        data_next.data_out     = s_tdata;
        data_next.frame_class  = class_next;
        data_next.frame_id     = id_next;
        data_next.frame_length = len_next;
    end

    // Parser state advances once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_SYNC_FIRST;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Output register.
    assign m_valid_next = accept || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg   <= data_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

// File: sv/ubxfp_checker.sv
`include "ubx_frame_parser_fletcher_top_assert.svh"

module ubxfp_checker
    import ubxfp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [7:0]           cfg_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [7:0]           s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [55:0]          m_tdata,
    input logic [2:0]           m_tuser,
    input logic                 m_tlast
);

    logic unused_cfg;
    logic unused_in;

    assign unused_cfg = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data);
    assign unused_in  = s_tvalid ^ s_tready ^ (^s_tdata);

    // Only a checksum verdict ends a frame.
    `UBXFP_ASSERT_IMPL(a_last_is_verdict, m_tvalid && m_tlast, (m_tuser == ST_GOOD) || (m_tuser == ST_BAD), "frame end without checksum verdict")

    // A payload offset is reported for payload bytes only.
    `UBXFP_ASSERT_IMPL(a_offset_on_payload, m_tvalid && (m_tdata[23:8] != 16'd0), m_tuser == ST_PAY, "payload offset outside payload")

    // A stalled result holds.
    `UBXFP_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Nothing is pending right after reset.
    `UBXFP_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind ubx_frame_parser_fletcher_top ubxfp_checker u_ubxfp_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ubxfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int GAP_PERCENT    = 19;
    localparam int MAX_REPORTS    = 100;

    // One expected result: status, the tdata fields and the end-of-frame flag.
    typedef struct packed {
        status_t      status;
        result_data_t fields;
        logic         frame_end;
    } parse_result_t;

    // Shapes of byte sequences offered to the parser.
    typedef enum int {
        FR_GOOD,
        FR_BAD_A,
        FR_BAD_B,
        FR_BAD_SYNC,
        FR_NOISE
    } frame_kind_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [55:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    // Shared controls of the two stream sides.
    bit no_idle     = 1'b0;
    bit hold_toggle = 1'b0;
    int mismatches  = 0;
    int result_count = 0;

    // Predictor state and its copy of the sync registers.
    pos_t       fp_pos;
    logic [7:0] fp_class;
    logic [7:0] fp_id;
    logic [15:0] fp_len;
    logic [7:0] fp_sum_a;
    logic [7:0] fp_sum_b;
    logic [7:0] sync_first_q;
    logic [7:0] sync_second_q;

    parse_result_t expected_results[$];

    ubx_frame_parser_fletcher_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Running Fletcher pair over header and payload bytes.
    function automatic void fold_into_sums(input logic [7:0] b);
        fp_sum_a = fp_sum_a + b;
        fp_sum_b = fp_sum_b + fp_sum_a;
    endfunction

    function automatic void restart_parser();
        fp_pos   = POS_SYNC_FIRST;
        fp_sum_a = 8'd0;
        fp_sum_b = 8'd0;
    endfunction

    // Advances the predicted parser by one byte and returns the result it gives.
    function automatic parse_result_t parse_byte(input logic [7:0] b);
        parse_result_t r;
        pos_t          ck_pos;
        ck_pos = POS_PAYLOAD + pos_t'(fp_len);
        r.status                = ST_HUNT;
        r.fields.data_out       = b;
        r.fields.payload_offset = 16'd0;
        r.frame_end             = 1'b0;
        if (fp_pos == POS_SYNC_FIRST) begin
            fp_pos = (b == sync_first_q) ? POS_SYNC_SECOND : POS_SYNC_FIRST;
        end else if (fp_pos == POS_SYNC_SECOND) begin
            // A mismatch goes back to hunting without looking at this byte again.
            fp_pos = (b == sync_second_q) ? POS_CLASS : POS_SYNC_FIRST;
        end else if (fp_pos < POS_PAYLOAD) begin
            case (fp_pos)
                POS_CLASS:   fp_class = b;
                POS_ID:      fp_id = b;
                POS_LEN_LOW: fp_len[7:0] = b;
                default:     fp_len[15:8] = b;
            endcase
            fold_into_sums(b);
            r.status = ST_HDR;
            fp_pos   = fp_pos + 1'b1;
        end else if (fp_pos < ck_pos) begin
            r.fields.payload_offset = 16'(fp_pos - POS_PAYLOAD);
            fold_into_sums(b);
            r.status = ST_PAY;
            fp_pos   = fp_pos + 1'b1;
        end else if (fp_pos == ck_pos) begin
            if (b == fp_sum_a) begin
                r.status = ST_CKA;
                fp_pos   = fp_pos + 1'b1;
            end else begin
                r.status    = ST_BAD;
                r.frame_end = 1'b1;
                restart_parser();
            end
        end else if (fp_pos == ck_pos + 1'b1) begin
            r.status    = (b == fp_sum_b) ? ST_GOOD : ST_BAD;
            r.frame_end = 1'b1;
            restart_parser();
        end else begin
            restart_parser();
        end
        r.fields.frame_class  = fp_class;
        r.fields.frame_id     = fp_id;
        r.fields.frame_length = fp_len;
        return r;
    endfunction

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                     what, got, want, result_count);
        mismatches++;
    endtask

    // Offers one byte and records its expected result once the transaction is taken.
    task automatic send_byte(input logic [7:0] b);
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(parse_byte(b));
    endtask

    task automatic send_bytes(ref logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // Builds a byte sequence of the given shape with the current sync bytes.
    task automatic build_frame(input frame_kind_t kind, input logic [7:0] cls,
                               input logic [7:0] id, input logic [15:0] len,
                               ref logic [7:0] q[$]);
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] b;
        int         i;
        q.delete();
        if (kind == FR_NOISE) begin
            // Noise never holds the first sync byte, so the next frame starts cleanly.
            repeat ($urandom_range(1, 4)) begin
                b = 8'($urandom);
                if (b == sync_first_q) b = b ^ 8'h01;
                q.push_back(b);
            end
            return;
        end
        q.push_back(sync_first_q);
        if (kind == FR_BAD_SYNC) begin
            b = 8'($urandom);
            if (b == sync_second_q) b = b ^ 8'h80;
            q.push_back(b);
            return;
        end
        q.push_back(sync_second_q);
        q.push_back(cls);
        q.push_back(id);
        q.push_back(len[7:0]);
        q.push_back(len[15:8]);
        repeat (len) q.push_back(8'($urandom));
        sa = 8'd0;
        sb = 8'd0;
        for (i = 2; i < q.size(); i++) begin
            sa = sa + q[i];
            sb = sb + sa;
        end
        if (kind == FR_BAD_A) begin
            // The second checksum byte is left out after a bad first one.
            q.push_back(sa ^ 8'($urandom_range(1, 255)));
            return;
        end
        if (kind == FR_BAD_B) sb = sb ^ 8'($urandom_range(1, 255));
        q.push_back(sa);
        q.push_back(sb);
    endtask

    // Waits until every expected result has been taken, then lets the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  sync_first_q = v;
            CFG_SYNC_SECOND: sync_second_q = v;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
        write_reg(CFG_SYNC_FIRST, first);
        write_reg(CFG_SYNC_SECOND, second);
    endtask

    // Mostly well-formed frames with random content, with broken ones mixed in.
    task automatic send_random_frames(input int n_items);
        int          sent;
        int          pick;
        frame_kind_t kind;
        logic [15:0] len;
        logic [7:0]  q[$];
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70)      kind = FR_GOOD;
            else if (pick < 78) kind = FR_BAD_A;
            else if (pick < 86) kind = FR_BAD_B;
            else if (pick < 93) kind = FR_BAD_SYNC;
            else                kind = FR_NOISE;
            if ($urandom_range(99) < 85) len = 16'($urandom_range(12));
            else                         len = 16'($urandom_range(13, 40));
            build_frame(kind, 8'($urandom), 8'($urandom), len, q);
            send_bytes(q);
            sent += q.size();
        end
    endtask

    // Sync recheck, header extremes and every checksum outcome.
    task automatic test_directed();
        logic [7:0] q[$];
        q = '{sync_first_q, sync_first_q, sync_second_q};
        send_bytes(q);
        build_frame(FR_GOOD, 8'hFF, 8'h00, 16'd1, q);
        send_bytes(q);
        build_frame(FR_BAD_A, 8'h00, 8'hFF, 16'd0, q);
        send_bytes(q);
        build_frame(FR_BAD_B, 8'h5A, 8'hA5, 16'd0, q);
        send_bytes(q);
        drain_results();
    endtask

    task automatic test_random_mix(input int n_items);
        send_random_frames(n_items);
        drain_results();
    endtask

    // Sync bytes at the ends of their range, in both orders.
    task automatic test_sync_extremes();
        set_sync(8'h00, 8'hFF);
        test_directed();
        test_random_mix(150);
        set_sync(8'hFF, 8'h00);
        test_random_mix(150);
    endtask

    // Both sync bytes alike, so a repeated first byte completes the preamble.
    task automatic test_equal_sync();
        set_sync(8'h55, 8'h55);
        test_random_mix(100);
    endtask

    task automatic test_back_to_back();
        set_sync(SYNC_FIRST_RESET, SYNC_SECOND_RESET);
        no_idle = 1'b1;
        test_random_mix(150);
        no_idle = 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        no_idle     = 1'b1;
        hold_toggle = ~hold_toggle;
        send_random_frames(100);
        no_idle = 1'b0;
        drain_results();
    endtask

    // A payload long enough to carry the length and the offset into their upper byte.
    task automatic test_long_payload();
        logic [7:0] q[$];
        build_frame(FR_GOOD, 8'($urandom), 8'($urandom), 16'h0101, q);
        send_bytes(q);
        drain_results();
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin : result_sink
        bit hold_seen;
        int hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= GAP_PERCENT);
            end
        end
    end

    // Compares every result transaction with the oldest expectation.
    initial begin : result_checker
        parse_result_t want;
        result_data_t  got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata;
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 64'(m_tdata), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(m_tuser), 64'(want.status));
                    if (got.data_out !== want.fields.data_out)
                        report_mismatch("data_out", 64'(got.data_out),
                                        64'(want.fields.data_out));
                    if (got.payload_offset !== want.fields.payload_offset)
                        report_mismatch("payload_offset", 64'(got.payload_offset),
                                        64'(want.fields.payload_offset));
                    if (got.frame_class !== want.fields.frame_class)
                        report_mismatch("frame_class", 64'(got.frame_class),
                                        64'(want.fields.frame_class));
                    if (got.frame_id !== want.fields.frame_id)
                        report_mismatch("frame_id", 64'(got.frame_id),
                                        64'(want.fields.frame_id));
                    if (got.frame_length !== want.fields.frame_length)
                        report_mismatch("frame_length", 64'(got.frame_length),
                                        64'(want.fields.frame_length));
                    if (m_tlast !== want.frame_end)
                        report_mismatch("frame_end", 64'(m_tlast), 64'(want.frame_end));
                end
            end
        end
    end

    // Ends the run when no transaction of any kind has happened for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transaction for %0d cycles", quiet);
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= 8'd0;
        sync_first_q  = SYNC_FIRST_RESET;
        sync_second_q = SYNC_SECOND_RESET;
        fp_class = 8'd0;
        fp_id    = 8'd0;
        fp_len   = 16'd0;
        restart_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_mix(150);
        test_sync_extremes();
        test_equal_sync();
        test_back_to_back();
        test_backpressure();
        test_long_payload();
        drain_results();

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 64'(expected_results.size()), 64'd0);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
